[design/dss_pkg.sv]
package dss_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int STEP_FIELD_W = 6;
   localparam int PAD_FIELD_W = 4;
   localparam int POS_W = 32;
   localparam int LEN_W = 18;
   localparam int DIV_STEPS = 32;

   localparam logic [2:0] FUNC_TICK = 3'd0;
   localparam logic [2:0] FUNC_WRITE = 3'd1;
   localparam logic [2:0] FUNC_START = 3'd2;
   localparam logic [2:0] FUNC_STOP = 3'd3;
   localparam logic [2:0] FUNC_NOTE = 3'd4;

   localparam logic [1:0] MSG_NOTE_ON = 2'd0;
   localparam logic [1:0] MSG_NOTE_OFF = 2'd1;
   localparam logic [1:0] MSG_CC = 2'd2;

   localparam logic [2:0] CSR_SAMPLES_PER_BEAT = 3'd0;
   localparam logic [2:0] CSR_PAD_NOTE_BASE = 3'd1;
   localparam logic [2:0] CSR_LED_CC_BASE = 3'd2;
   localparam logic [2:0] CSR_OUT_CHANNEL = 3'd3;
   localparam logic [2:0] CSR_CLICK_ON = 3'd4;

   localparam logic [19:0] RST_SAMPLES_PER_BEAT = 20'd22050;
   localparam logic [6:0] RST_PAD_NOTE_BASE = 7'd36;
   localparam logic [6:0] RST_LED_CC_BASE = 7'd0;
   localparam logic [4:0] RST_OUT_CHANNEL = 5'd1;

   localparam logic [4:0] CLICK_CHANNEL = 5'd10;
   localparam logic [6:0] CLICK_NOTE = 7'd37;
   localparam logic [6:0] CLICK_VELOCITY = 7'd100;
   localparam logic [6:0] FULL_VALUE = 7'd127;
   localparam logic [4:0] CHANNEL_MIN = 5'd1;
   localparam logic [4:0] CHANNEL_MAX = 5'd16;

   typedef struct packed {
      logic [2:0] func;
      logic [15:0] elapsed_samples;
      logic [3:0] pad_sel;
      logic [3:0] step_sel;
      logic cell_active;
      logic [6:0] note_number;
      logic [6:0] note_velocity;
      logic note_is_on;
   } req_type;

   typedef struct packed {
      logic [1:0] msg_kind;
      logic [4:0] msg_channel;
      logic [6:0] msg_number;
      logic [6:0] msg_value;
      logic [3:0] step_now;
      logic last;
   } rsp_type;

   typedef struct packed {
      logic [19:0] samples_per_beat;
      logic [6:0] pad_note_base;
      logic [6:0] led_cc_base;
      logic [4:0] out_channel;
      logic click_on;
   } cfg_type;

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_STOP = 2'd2,
      CMD_NOTE = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [STEP_FIELD_W-1:0] step;
      logic [PAD_FIELD_W-1:0] pad;
      logic [STEP_FIELD_W-1:0] cell_step;
      logic flag;
   } cmd_type;

   typedef struct packed {
      logic valid;
      cmd_type cmd;
   } cmd_chan_type;

endpackage

[design/dss_queue.sv]
module dss_queue
   import dss_pkg::*;
(
   input logic clock,
   input logic reset,
   input cmd_chan_type push,
   output logic full,
   output cmd_chan_type head,
   input logic pop
);

   cmd_type entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign full = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd = entries_ff[rd_ptr_ff];
   assign do_push = push.valid && !full;
   assign do_pop = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

[design/dss_front.sv]
module dss_front
   import dss_pkg::*;
#(
   parameter int PADS = 16,
   parameter int STEPS = 16
) (
   input logic clock,
   input logic reset,
   input cfg_type cfg,
   input logic req_valid,
   output logic req_stall,
   input req_type req_data,
   output cmd_chan_type push,
   input logic full
);

   localparam int STEP_W = $clog2(STEPS);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_DIV = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type state_ff, state_in;
   logic playing_ff, playing_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   cmd_type cmd_ff, cmd_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [POS_W-1:0] dvd_ff, dvd_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [STEP_W-1:0] adv_ff, adv_in;

   logic [LEN_W-1:0] len;
   logic [POS_W-1:0] sum;
   logic [LEN_W:0] shifted;
   logic ge;
   logic [LEN_W-1:0] rem_next;
   logic [STEP_W:0] q2;
   logic [STEP_W-1:0] adv_next;
   logic [STEP_W:0] step_sum;
   logic [STEP_W-1:0] step_next;
   logic [7:0] note_diff;
   logic note_hit;

   assign req_stall = (state_ff != F_IDLE);
   assign push.valid = (state_ff == F_PUSH);
   assign push.cmd = cmd_ff;

   always_comb begin
      len = cfg.samples_per_beat[19:2];
      sum = pos_ff + POS_W'(req_data.elapsed_samples);
      shifted = {rem_ff, dvd_ff[POS_W-1]};
      ge = (shifted >= {1'b0, len});
      rem_next = ge ? LEN_W'(shifted - {1'b0, len}) : LEN_W'(shifted);
      q2 = {adv_ff, ge};
      adv_next = (q2 >= (STEP_W+1)'(STEPS)) ? STEP_W'(q2 - (STEP_W+1)'(STEPS)) : STEP_W'(q2);
      step_sum = {1'b0, step_ff} + {1'b0, adv_next};
      step_next = (step_sum >= (STEP_W+1)'(STEPS)) ?
                  STEP_W'(step_sum - (STEP_W+1)'(STEPS)) : STEP_W'(step_sum);
      note_diff = {1'b0, req_data.note_number} - {1'b0, cfg.pad_note_base};
      note_hit = (req_data.note_number >= cfg.pad_note_base) && (32'(note_diff) < PADS);
   end

   always_comb begin
      state_in = state_ff;
      playing_in = playing_ff;
      step_in = step_ff;
      pos_in = pos_ff;
      cmd_in = cmd_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      cnt_in = cnt_ff;
      adv_in = adv_ff;
      case (state_ff)
         F_IDLE: begin
            cmd_in.step = STEP_FIELD_W'(step_ff);
            cmd_in.pad = req_data.pad_sel;
            cmd_in.cell_step = STEP_FIELD_W'(req_data.step_sel);
            cmd_in.flag = req_data.cell_active;
            if (req_valid) begin
               case (req_data.func)
                  FUNC_TICK: begin
                     if (playing_ff) begin
                        cmd_in.kind = CMD_TICK;
                        if (len != '0 && sum >= POS_W'(len)) begin
                           dvd_in = sum;
                           rem_in = '0;
                           adv_in = '0;
                           cnt_in = 5'(DIV_STEPS - 1);
                           state_in = F_DIV;
                        end else begin
                           pos_in = sum;
                           state_in = F_PUSH;
                        end
                     end
                  end
                  FUNC_WRITE: begin
                     if (32'(req_data.pad_sel) < PADS && 32'(req_data.step_sel) < STEPS) begin
                        cmd_in.kind = CMD_WRITE;
                        state_in = F_PUSH;
                     end
                  end
                  FUNC_START: begin
                     if (!playing_ff) begin
                        playing_in = 1'b1;
                        step_in = '0;
                        pos_in = '0;
                     end
                  end
                  FUNC_STOP: begin
                     if (playing_ff) begin
                        playing_in = 1'b0;
                        cmd_in.kind = CMD_STOP;
                        state_in = F_PUSH;
                     end
                  end
                  FUNC_NOTE: begin
                     if (note_hit) begin
                        cmd_in.kind = CMD_NOTE;
                        cmd_in.pad = note_diff[PAD_FIELD_W-1:0];
                        cmd_in.flag = req_data.note_is_on && (req_data.note_velocity != '0);
                        state_in = F_PUSH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         F_DIV: begin
            rem_in = rem_next;
            dvd_in = {dvd_ff[POS_W-2:0], 1'b0};
            adv_in = adv_next;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               pos_in = POS_W'(rem_next);
               step_in = step_next;
               cmd_in.step = STEP_FIELD_W'(step_next);
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      cnt_ff <= cnt_in;
      adv_ff <= adv_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         playing_ff <= 1'b0;
         step_ff <= '0;
         pos_ff <= '0;
      end else begin
         state_ff <= state_in;
         playing_ff <= playing_in;
         step_ff <= step_in;
         pos_ff <= pos_in;
      end
   end

endmodule

[design/dss_back.sv]
module dss_back
   import dss_pkg::*;
#(
   parameter int PADS = 16,
   parameter int STEPS = 16
) (
   input logic clock,
   input logic reset,
   input cfg_type cfg,
   input cmd_chan_type head,
   output logic pop,
   output logic rsp_valid,
   input logic rsp_stall,
   output rsp_type rsp_data
);

   localparam int STEP_W = $clog2(STEPS);
   localparam int PAD_W = (PADS > 1) ? $clog2(PADS) : 1;

   typedef enum logic [4:0] {
      B_IDLE = 5'b00001,
      B_PAD = 5'b00010,
      B_CLICK_ON = 5'b00100,
      B_CLICK_OFF = 5'b01000,
      B_STOP = 5'b10000
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [PAD_W-1:0] pad_ff, pad_in;
   logic phase_ff, phase_in;
   logic [3:0] cur_step_ff, cur_step_in;
   logic click_step_ff, click_step_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   logic [PADS-1:0] pattern_ff [STEPS];
   logic [STEPS-1:0] row_valid_ff;
   logic [PADS-1:0] rd_row_ff;
   logic rd_ok_ff;

   logic fire;
   logic emit;
   rsp_type msg;
   logic rd_en;
   logic wr_en;
   logic [STEP_W-1:0] rd_step;
   logic [STEP_W-1:0] wr_step;
   logic [PAD_W-1:0] wr_pad;
   logic [PADS-1:0] row;
   logic hit;
   logic pad_last;
   logic click_due;
   logic [4:0] chan;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign fire = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rd_step = head.cmd.step[STEP_W-1:0];
      wr_step = head.cmd.cell_step[STEP_W-1:0];
      wr_pad = head.cmd.pad[PAD_W-1:0];
      row = rd_ok_ff ? rd_row_ff : '0;
      hit = row[pad_ff];
      pad_last = (pad_ff == PAD_W'(PADS - 1));
      click_due = cfg.click_on && click_step_ff;
      if (cfg.out_channel < CHANNEL_MIN) begin
         chan = CHANNEL_MIN;
      end else if (cfg.out_channel > CHANNEL_MAX) begin
         chan = CHANNEL_MAX;
      end else begin
         chan = cfg.out_channel;
      end
   end

   always_comb begin
      state_in = state_ff;
      pad_in = pad_ff;
      phase_in = phase_ff;
      cur_step_in = cur_step_ff;
      click_step_in = click_step_ff;
      pop = 1'b0;
      emit = 1'b0;
      rd_en = 1'b0;
      wr_en = 1'b0;
      msg.msg_kind = MSG_CC;
      msg.msg_channel = chan;
      msg.msg_number = cfg.led_cc_base + 7'(pad_ff);
      msg.msg_value = '0;
      msg.step_now = cur_step_ff;
      msg.last = 1'b0;
      case (state_ff)
         B_IDLE: begin
            pad_in = '0;
            phase_in = 1'b0;
            cur_step_in = head.cmd.step[3:0];
            click_step_in = (head.cmd.step[1:0] == 2'b00);
            if (head.valid) begin
               case (head.cmd.kind)
                  CMD_TICK: begin
                     pop = 1'b1;
                     rd_en = 1'b1;
                     state_in = B_PAD;
                  end
                  CMD_WRITE: begin
                     pop = 1'b1;
                     wr_en = 1'b1;
                  end
                  CMD_STOP: begin
                     pop = 1'b1;
                     state_in = B_STOP;
                  end
                  CMD_NOTE: begin
                     if (fire) begin
                        pop = 1'b1;
                        emit = 1'b1;
                        msg.msg_number = cfg.led_cc_base + 7'(head.cmd.pad);
                        msg.msg_value = head.cmd.flag ? FULL_VALUE : '0;
                        msg.step_now = head.cmd.step[3:0];
                        msg.last = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         B_PAD: begin
            if (fire) begin
               emit = 1'b1;
               if (hit && !phase_ff) begin
                  msg.msg_kind = MSG_NOTE_ON;
                  msg.msg_number = cfg.pad_note_base + 7'(pad_ff);
                  msg.msg_value = FULL_VALUE;
                  phase_in = 1'b1;
               end else begin
                  msg.msg_value = hit ? FULL_VALUE : '0;
                  phase_in = 1'b0;
                  pad_in = pad_ff + 1'b1;
                  if (pad_last) begin
                     msg.last = !click_due;
                     state_in = click_due ? B_CLICK_ON : B_IDLE;
                  end
               end
            end
         end
         B_CLICK_ON: begin
            if (fire) begin
               emit = 1'b1;
               msg.msg_kind = MSG_NOTE_ON;
               msg.msg_channel = CLICK_CHANNEL;
               msg.msg_number = CLICK_NOTE;
               msg.msg_value = CLICK_VELOCITY;
               state_in = B_CLICK_OFF;
            end
         end
         B_CLICK_OFF: begin
            if (fire) begin
               emit = 1'b1;
               msg.msg_kind = MSG_NOTE_OFF;
               msg.msg_channel = CLICK_CHANNEL;
               msg.msg_number = CLICK_NOTE;
               msg.last = 1'b1;
               state_in = B_IDLE;
            end
         end
         B_STOP: begin
            if (fire) begin
               emit = 1'b1;
               if (!phase_ff) begin
                  msg.msg_kind = MSG_NOTE_OFF;
                  msg.msg_number = cfg.pad_note_base + 7'(pad_ff);
                  phase_in = 1'b1;
               end else begin
                  phase_in = 1'b0;
                  pad_in = pad_ff + 1'b1;
                  if (pad_last) begin
                     msg.last = 1'b1;
                     state_in = B_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   // A row that was never written reads as all clear; its first write sets the whole row, clearing every other pad.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (row_valid_ff[wr_step]) begin
            pattern_ff[wr_step][wr_pad] <= head.cmd.flag;
         end else begin
            pattern_ff[wr_step] <= PADS'(head.cmd.flag) << wr_pad;
         end
      end
      if (rd_en) begin
         rd_row_ff <= pattern_ff[rd_step];
         rd_ok_ff <= row_valid_ff[rd_step];
      end
   end

   always_ff @(posedge clock) begin
      pad_ff <= pad_in;
      phase_ff <= phase_in;
      cur_step_ff <= cur_step_in;
      click_step_ff <= click_step_in;
      if (emit) begin
         rsp_data_ff <= msg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            row_valid_ff[wr_step] <= 1'b1;
         end
      end
   end

endmodule

[design/drum_step_sequencer_core.sv]
// A tick that moves the step passes through the front as accept, remainder divider, hand-off;
// a playing tick that keeps its step, a write, a stop or a pad note skips the divider; others end at accept.
// Results are registered and follow one beat per cycle while the receiver does not stall:
// up to 34 for a tick, 32 for a stop; the front takes new items while the back still sends beats.
// Synchronous reset stops playback, zeroes step and position, marks every pattern row as
// cleared and loads the register defaults; the block takes items in the cycle after reset.
module drum_step_sequencer_core
   import dss_pkg::*;
#(
   parameter int PADS = 16,
   parameter int STEPS = 16
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output rsp_type rsp_data,
   input logic csr_valid,
   output logic csr_ready,
   input logic [2:0] csr_index,
   input logic [19:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   cmd_chan_type push;
   cmd_chan_type head;
   logic full;
   logic pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SAMPLES_PER_BEAT: cfg_in.samples_per_beat = csr_wdata;
            CSR_PAD_NOTE_BASE: cfg_in.pad_note_base = csr_wdata[6:0];
            CSR_LED_CC_BASE: cfg_in.led_cc_base = csr_wdata[6:0];
            CSR_OUT_CHANNEL: cfg_in.out_channel = csr_wdata[4:0];
            CSR_CLICK_ON: cfg_in.click_on = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.samples_per_beat <= RST_SAMPLES_PER_BEAT;
         cfg_ff.pad_note_base <= RST_PAD_NOTE_BASE;
         cfg_ff.led_cc_base <= RST_LED_CC_BASE;
         cfg_ff.out_channel <= RST_OUT_CHANNEL;
         cfg_ff.click_on <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dss_front #(
      .PADS(PADS),
      .STEPS(STEPS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .push(push),
      .full(full)
   );

   dss_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .head(head),
      .pop(pop)
   );

   dss_back #(
      .PADS(PADS),
      .STEPS(STEPS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .head(head),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

endmodule

[test/seq_msg_checker.sv]
module seq_msg_checker
   import dss_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input req_type req_data,
   input logic rsp_valid,
   input logic rsp_stall,
   input rsp_type rsp_data,
   input logic csr_valid,
   input logic csr_ready,
   input logic [2:0] csr_index,
   input logic [19:0] csr_wdata,
   output int fail_count,
   output int pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAD_COUNT = 16;

   cfg_type live_cfg;
   logic [15:0] hit_grid [PAD_COUNT];
   logic [3:0] cur_step;
   logic [31:0] pos_acc;
   logic running;
   rsp_type due_msgs [$];
   int shown;

   function automatic rsp_type sequencer_msg(input logic [1:0] kind, input logic [4:0] chan,
         input logic [6:0] num, input logic [6:0] val);
      rsp_type m;
      m.msg_kind = kind;
      m.msg_channel = chan;
      m.msg_number = num;
      m.msg_value = val;
      m.step_now = cur_step;
      m.last = 1'b0;
      return m;
   endfunction

   task automatic predict_item(input req_type item);
      rsp_type batch [$];
      rsp_type m;
      logic [4:0] chan;
      logic [17:0] step_len;
      logic [31:0] steps_moved;
      logic [6:0] pad_ofs;
      int note_int;
      int base_int;
      if (live_cfg.out_channel < CHANNEL_MIN) chan = CHANNEL_MIN;
      else if (live_cfg.out_channel > CHANNEL_MAX) chan = CHANNEL_MAX;
      else chan = live_cfg.out_channel;
      case (item.func)
         FUNC_TICK: begin
            if (running) begin
               pos_acc = pos_acc + {16'd0, item.elapsed_samples};
               step_len = live_cfg.samples_per_beat[19:2];
               if (step_len != 18'd0 && pos_acc >= {14'd0, step_len}) begin
                  steps_moved = pos_acc / {14'd0, step_len};
                  cur_step = cur_step + steps_moved[3:0];
                  pos_acc = pos_acc % {14'd0, step_len};
               end
               for (int p = 0; p < PAD_COUNT; p++) begin
                  pad_ofs = p[6:0];
                  if (hit_grid[p][cur_step]) begin
                     batch.push_back(sequencer_msg(MSG_NOTE_ON, chan,
                        live_cfg.pad_note_base + pad_ofs, FULL_VALUE));
                     batch.push_back(sequencer_msg(MSG_CC, chan,
                        live_cfg.led_cc_base + pad_ofs, FULL_VALUE));
                  end else begin
                     batch.push_back(sequencer_msg(MSG_CC, chan,
                        live_cfg.led_cc_base + pad_ofs, 7'd0));
                  end
               end
               if (live_cfg.click_on && cur_step[1:0] == 2'd0) begin
                  batch.push_back(sequencer_msg(MSG_NOTE_ON, CLICK_CHANNEL, CLICK_NOTE,
                     CLICK_VELOCITY));
                  batch.push_back(sequencer_msg(MSG_NOTE_OFF, CLICK_CHANNEL, CLICK_NOTE, 7'd0));
               end
            end
         end
         FUNC_WRITE: begin
            hit_grid[item.pad_sel][item.step_sel] = item.cell_active;
         end
         FUNC_START: begin
            if (!running) begin
               running = 1'b1;
               cur_step = '0;
               pos_acc = '0;
            end
         end
         FUNC_STOP: begin
            if (running) begin
               running = 1'b0;
               for (int p = 0; p < PAD_COUNT; p++) begin
                  pad_ofs = p[6:0];
                  batch.push_back(sequencer_msg(MSG_NOTE_OFF, chan,
                     live_cfg.pad_note_base + pad_ofs, 7'd0));
                  batch.push_back(sequencer_msg(MSG_CC, chan,
                     live_cfg.led_cc_base + pad_ofs, 7'd0));
               end
            end
         end
         FUNC_NOTE: begin
            note_int = item.note_number;
            base_int = live_cfg.pad_note_base;
            if (note_int >= base_int && note_int < base_int + PAD_COUNT) begin
               pad_ofs = item.note_number - live_cfg.pad_note_base;
               batch.push_back(sequencer_msg(MSG_CC, chan, live_cfg.led_cc_base + pad_ofs,
                  (item.note_is_on && item.note_velocity != 7'd0) ? FULL_VALUE : 7'd0));
            end
         end
         default: begin
         end
      endcase
      foreach (batch[i]) begin
         m = batch[i];
         m.last = (i == batch.size() - 1);
         due_msgs.push_back(m);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         live_cfg.samples_per_beat = RST_SAMPLES_PER_BEAT;
         live_cfg.pad_note_base = RST_PAD_NOTE_BASE;
         live_cfg.led_cc_base = RST_LED_CC_BASE;
         live_cfg.out_channel = RST_OUT_CHANNEL;
         live_cfg.click_on = 1'b0;
         foreach (hit_grid[p]) hit_grid[p] = '0;
         cur_step = '0;
         pos_acc = '0;
         running = 1'b0;
         due_msgs.delete();
         fail_count = 0;
         shown = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SAMPLES_PER_BEAT: live_cfg.samples_per_beat = csr_wdata;
               CSR_PAD_NOTE_BASE: live_cfg.pad_note_base = csr_wdata[6:0];
               CSR_LED_CC_BASE: live_cfg.led_cc_base = csr_wdata[6:0];
               CSR_OUT_CHANNEL: live_cfg.out_channel = csr_wdata[4:0];
               CSR_CLICK_ON: live_cfg.click_on = csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) predict_item(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (due_msgs.size() == 0) begin
               fail_count++;
               if (shown < 10) begin
                  shown++;
                  $display("%t: unexpected beat kind %0d ch %0d num %0d val %0d step %0d last %0d",
                     $time, rsp_data.msg_kind, rsp_data.msg_channel, rsp_data.msg_number,
                     rsp_data.msg_value, rsp_data.step_now, rsp_data.last);
               end
            end else begin
               want = due_msgs.pop_front();
               if (rsp_data.msg_kind !== want.msg_kind ||
                     rsp_data.msg_channel !== want.msg_channel ||
                     rsp_data.msg_number !== want.msg_number ||
                     rsp_data.msg_value !== want.msg_value ||
                     rsp_data.step_now !== want.step_now ||
                     rsp_data.last !== want.last) begin
                  fail_count++;
                  if (shown < 10) begin
                     shown++;
                     $display("%t: beat mismatch, expected kind %0d ch %0d num %0d val %0d",
                        $time, want.msg_kind, want.msg_channel, want.msg_number,
                        want.msg_value, " step %0d last %0d", want.step_now, want.last);
                     $display("   got kind %0d ch %0d num %0d val %0d step %0d last %0d",
                        rsp_data.msg_kind, rsp_data.msg_channel, rsp_data.msg_number,
                        rsp_data.msg_value, rsp_data.step_now, rsp_data.last);
                  end
               end
            end
         end
      end
      pending <= due_msgs.size();
   end

endmodule

[test/drum_step_sequencer_core_tb.sv]
module drum_step_sequencer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dss_pkg::*;

   localparam int HOLD_CYCLES = 400;
   localparam int QUIET_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 120;
   localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
   localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
   localparam logic [2:0] CSR_SPARE = 3'd5;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [19:0] csr_wdata = '0;

   int fail_count;
   int pending;
   int idle_pct = 34;
   int holds_asked = 0;
   int holds_taken = 0;
   int hold_left = 0;
   int quiet = 0;
   logic [6:0] note_base_now = RST_PAD_NOTE_BASE;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   drum_step_sequencer_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   seq_msg_checker watcher (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .pending(pending)
   );

   // The receiver stalls at random, or holds off for a long stretch when asked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (holds_taken < holds_asked) begin
         holds_taken = holds_taken + 1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
            (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet == QUIET_LIMIT) begin
         $display("drum_step_sequencer_core_tb: errors");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   function automatic req_type noise_item(input logic [2:0] func);
      req_type it;
      it.func = func;
      it.elapsed_samples = 16'($urandom);
      it.pad_sel = 4'($urandom);
      it.step_sel = 4'($urandom);
      it.cell_active = 1'($urandom);
      it.note_number = 7'($urandom);
      it.note_velocity = 7'($urandom);
      it.note_is_on = 1'($urandom);
      return it;
   endfunction

   function automatic req_type random_item();
      req_type it;
      int pick;
      pick = $urandom_range(99);
      it = noise_item(FUNC_TICK);
      if ($urandom_range(3) != 0) it.elapsed_samples = 16'($urandom_range(3000));
      if (pick >= 95) begin
         it.func = 3'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
      end else if (pick >= 79) begin
         it.func = FUNC_NOTE;
         if ($urandom_range(4) != 0) it.note_number = note_base_now + 7'($urandom_range(19)) - 7'd2;
         if ($urandom_range(7) == 0) it.note_velocity = 7'd0;
      end else if (pick >= 73) begin
         it.func = FUNC_STOP;
      end else if (pick >= 65) begin
         it.func = FUNC_START;
      end else if (pick >= 45) begin
         it.func = FUNC_WRITE;
      end
      return it;
   endfunction

   // Valid stays high from one beat to the next unless a gap is taken.
   task automatic offer(input req_type item);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(5, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_cmd(input logic [2:0] func);
      offer(noise_item(func));
   endtask

   task automatic send_tick(input logic [15:0] samples);
      req_type it;
      it = noise_item(FUNC_TICK);
      it.elapsed_samples = samples;
      offer(it);
   endtask

   task automatic send_cell(input logic [3:0] pad, input logic [3:0] step, input logic hit);
      req_type it;
      it = noise_item(FUNC_WRITE);
      it.pad_sel = pad;
      it.step_sel = step;
      it.cell_active = hit;
      offer(it);
   endtask

   task automatic send_note(input logic [6:0] num, input logic [6:0] vel, input logic on);
      req_type it;
      it = noise_item(FUNC_NOTE);
      it.note_number = num;
      it.note_velocity = vel;
      it.note_is_on = on;
      offer(it);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [19:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic load_regs(input logic [19:0] spb, input logic [6:0] pad_base,
         input logic [6:0] cc_base, input logic [4:0] chan, input logic click);
      write_reg(CSR_SPARE, 20'($urandom));
      write_reg(CSR_SAMPLES_PER_BEAT, spb);
      write_reg(CSR_PAD_NOTE_BASE, {13'($urandom), pad_base});
      write_reg(CSR_LED_CC_BASE, {13'($urandom), cc_base});
      write_reg(CSR_OUT_CHANNEL, {15'($urandom), chan});
      write_reg(CSR_CLICK_ON, {19'($urandom), click});
      csr_valid <= 1'b0;
      note_base_now = pad_base;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_tick(16'd100);
      send_cmd(FUNC_STOP);
      send_note(7'd36, 7'd127, 1'b1);
      send_note(7'd36, 7'd0, 1'b1);
      send_note(7'd51, 7'd50, 1'b0);
      send_note(7'd35, 7'd127, 1'b1);
      send_note(7'd52, 7'd127, 1'b1);
      send_cmd(FUNC_SPARE_LO);
      send_cmd(FUNC_SPARE_HI);
      send_cell(4'd0, 4'd0, 1'b1);
      send_cell(4'd15, 4'd15, 1'b1);
      send_cell(4'd3, 4'd4, 1'b1);
      send_cell(4'd3, 4'd4, 1'b0);
      send_cell(4'd7, 4'd11, 1'b1);
      send_cell(4'd9, 4'd12, 1'b1);
      send_cmd(FUNC_START);
      send_cmd(FUNC_START);
      send_tick(16'd0);
      send_tick(16'hFFFF);
      send_tick(16'd609);
      send_cmd(FUNC_STOP);
      send_cmd(FUNC_START);
      send_tick(16'd5511);
      settle();

      // A zero step length lets the position grow; the next setting folds it all at once.
      load_regs(20'd0, 7'd127, 7'd127, 5'd0, 1'b1);
      repeat (3) send_tick(16'hFFFF);
      send_note(7'd127, 7'd1, 1'b1);
      send_note(7'd0, 7'd127, 1'b1);
      settle();
      load_regs(20'd4, 7'd120, 7'd64, 5'd17, 1'b1);
      send_tick(16'd0);
      send_note(7'd125, 7'd90, 1'b1);
      send_tick(16'd3);
      settle();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: load_regs(20'hFFFFF, 7'd0, 7'd0, 5'd16, 1'b1);
            1: load_regs(20'($urandom_range(3, 1)), 7'($urandom), 7'($urandom), 5'd31,
                  1'($urandom));
            2: load_regs(20'($urandom_range(200, 4)), 7'($urandom), 7'($urandom),
                  5'($urandom), 1'b1);
            3: load_regs(20'($urandom_range(40000, 4)), 7'($urandom), 7'($urandom), 5'd1,
                  1'($urandom));
            default: load_regs(20'($urandom), 7'($urandom), 7'($urandom), 5'($urandom),
                  1'($urandom));
         endcase
         idle_pct = (phase == 2) ? 0 : 34;
         send_cmd(FUNC_START);
         if (phase == 3) begin
            holds_asked = holds_asked + 1;
            repeat (10) send_tick(16'($urandom_range(200)));
         end
         repeat (15) offer(random_item());
         settle();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("drum_step_sequencer_core_tb: clean");
      end else begin
         $display("drum_step_sequencer_core_tb: errors");
      end
      $finish;
   end

endmodule

[sim.f]
design/dss_pkg.sv
design/dss_queue.sv
design/dss_front.sv
design/dss_back.sv
design/drum_step_sequencer_core.sv
test/seq_msg_checker.sv
test/drum_step_sequencer_core_tb.sv
